/* hdl/skt_pkg.sv */
package skt_pkg;

  // Widths of the fields on the request and response channels.
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned DATA_W        = 16;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned ENTRY_COUNT_W = 9;

  // Operation codes carried in the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_FIND   = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_e;

  // Request payload.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] ref_key;
    logic [DATA_W-1:0] block_value;
  } req_t;

  // Response payload.
  typedef struct packed {
    status_e                  status;
    logic [DATA_W-1:0]        ref_out;
    logic [DATA_W-1:0]        block_out;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } rsp_t;

  // Operands broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] ref_key;
    logic [DATA_W-1:0] block_value;
    logic              insert;
  } cell_bcast_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_WAIT,
    S_COMMIT
  } state_e;

endpackage

/* hdl/skt_ifs.sv */
// Request channel: one table operation.
interface skt_req_if;
  import skt_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Response channel: one answer per operation.
interface skt_rsp_if;
  import skt_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/skt_cell.sv */
module skt_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned KW    = 16,
  parameter int unsigned PW    = 16,
  parameter int unsigned CNT_W = 9
) (
  input  logic                    clk_i,
  input  logic [CNT_W-1:0]        count_i,
  input  skt_pkg::cell_bcast_t    bcast_i,
  input  logic [2*KW+PW-1:0]      left_entry_i,
  input  logic                    left_after_i,
  output logic [2*KW+PW-1:0]      entry_o,
  output logic                    after_o,
  output logic [1+KW+PW-1:0]      leaf_o
);
  import skt_pkg::*;

  logic [KW-1:0] key_q, key_d;
  logic [KW-1:0] ref_q, ref_d;
  logic [PW-1:0] blk_q, blk_d;
  logic [KW-1:0] op_key;
  logic          occupied;
  logic          hit;

  // A cell holds a live entry when its place lies below the fill count.
  assign op_key   = bcast_i.key[KW-1:0];
  assign occupied = (CNT_W'(IDX) < count_i);
  assign hit      = occupied && (key_q == op_key);

  // The cell sits at or after the insert point when it is empty or holds
  // a larger key; the table is sorted, so this flag rises once along the row.
  assign after_o = !occupied || (key_q > op_key);

  assign entry_o = {key_q, ref_q, blk_q};

  // Matching entry for the OR tree; all other cells contribute zero.
  assign leaf_o = {hit, hit ? ref_q : '0, hit ? blk_q : '0};

  // Insert: cells past the insert point take their left neighbor's entry,
  // the cell at the insert point takes the new entry.
  always_comb begin
    key_d = key_q;
    ref_d = ref_q;
    blk_d = blk_q;
    if (bcast_i.insert && after_o) begin
      if (left_after_i) begin
        {key_d, ref_d, blk_d} = left_entry_i;
      end else begin
        key_d = op_key;
        ref_d = bcast_i.ref_key[KW-1:0];
        blk_d = bcast_i.block_value[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    ref_q <= ref_d;
    blk_q <= blk_d;
  end

endmodule

/* hdl/skt_reduce.sv */
module skt_reduce #(
  parameter int unsigned N = 256,
  parameter int unsigned W = 33
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [N*W-1:0] data_i,
  output logic           valid_o,
  output logic [W-1:0]   data_o
);
  localparam int unsigned GROUP = 16;
  localparam int unsigned M     = (N + GROUP - 1) / GROUP;

  logic [M*W-1:0] grp_q, grp_d;
  logic           valid_q;

  // Each group of up to sixteen inputs is ORed into one registered word.
  for (genvar j = 0; j < M; j++) begin : g_grp
    always_comb begin
      grp_d[j*W +: W] = '0;
      for (int e = 0; e < GROUP; e++) begin
        if (j * GROUP + e < N) begin
          grp_d[j*W +: W] = grp_d[j*W +: W] | data_i[(j*GROUP+e)*W +: W];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Further levels until a single word remains.
  if (M == 1) begin : g_last
    assign valid_o = valid_q;
    assign data_o  = grp_q[W-1:0];
  end else begin : g_next
    skt_reduce #(
      .N (M),
      .W (W)
    ) u_next (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_q),
      .data_i  (grp_q),
      .valid_o (valid_o),
      .data_o  (data_o)
    );
  end

endmodule

/* hdl/sorted_key_table.sv */
// Channel   Modport  Payload                                   Role
// req_i     sink     mode, key, ref_key, block_value           table operation
// rsp_o     source   status, ref_out, block_out, entry_count   one answer per operation
//
// One request is in flight at a time. From acceptance it passes the search step, a wait
// on the registered sixteen-way OR tree that collects the match from the cells
// (ceil(log16(DEPTH)) levels), and the commit step that loads the response; the
// controller is back in idle and accepts the next request once the response is loaded.
// Reset clears the fill count and the control state; the cells start empty.
// A new request is taken while the previous response still waits; a stalled response
// holds the operation in its final step until the response register frees up.
module sorted_key_table #(
  parameter int unsigned DEPTH        = 256,
  parameter int unsigned KEY_BITS     = 16,
  parameter int unsigned PAYLOAD_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  skt_req_if.sink   req_i,
  skt_rsp_if.source rsp_o
);
  import skt_pkg::*;

  localparam int unsigned KW    = (KEY_BITS < DATA_W) ? KEY_BITS : DATA_W;
  localparam int unsigned PW    = (PAYLOAD_BITS < DATA_W) ? PAYLOAD_BITS : DATA_W;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned ENT_W = 2 * KW + PW;
  localparam int unsigned LW    = 1 + KW + PW;

  state_e             state_q, state_d;
  req_t               op_q;
  logic [CNT_W-1:0]   count_q, count_d;
  rsp_t               rsp_q, rsp_d;
  logic               rsp_valid_q, rsp_valid_d;
  logic               hit_q;
  logic [KW-1:0]      ref_hit_q;
  logic [PW-1:0]      blk_hit_q;

  logic               req_fire;
  logic               commit;
  logic               ins_ok;
  logic               table_full;
  cell_bcast_t        bcast;

  logic [ENT_W-1:0]   ent   [DEPTH];
  logic               after [DEPTH];
  logic [DEPTH*LW-1:0] leaves;
  logic               tree_valid;
  logic [LW-1:0]      tree_data;

  assign req_fire = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  // Operation decode for the final step.
  assign table_full = (count_q == CNT_W'(DEPTH));
  assign ins_ok     = (op_q.mode == MODE_INSERT) && !hit_q && !table_full;
  assign commit     = (state_q == S_COMMIT) && (!rsp_valid_q || rsp_o.ready);

  // Operands seen by every cell.
  assign bcast.key         = op_q.key;
  assign bcast.ref_key     = op_q.ref_key;
  assign bcast.block_value = op_q.block_value;
  assign bcast.insert      = commit && ins_ok;

  // The chain of cells, each handing its entry to its right neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ENT_W-1:0] left_entry;
    logic             left_after;

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_after = 1'b0;
    end else begin : g_body
      assign left_entry = ent[i-1];
      assign left_after = after[i-1];
    end

    skt_cell #(
      .IDX   (i),
      .KW    (KW),
      .PW    (PW),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .count_i      (count_q),
      .bcast_i      (bcast),
      .left_entry_i (left_entry),
      .left_after_i (left_after),
      .entry_o      (ent[i]),
      .after_o      (after[i]),
      .leaf_o       (leaves[i*LW +: LW])
    );
  end

  // Registered OR tree collecting the one matching entry, if any.
  skt_reduce #(
    .N (DEPTH),
    .W (LW)
  ) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (state_q == S_SEARCH),
    .data_i  (leaves),
    .valid_o (tree_valid),
    .data_o  (tree_data)
  );

  // Next state, fill count and response.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (tree_valid) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (commit) begin
          state_d           = S_IDLE;
          rsp_valid_d       = 1'b1;
          rsp_d.status      = ST_OK;
          rsp_d.ref_out     = '0;
          rsp_d.block_out   = '0;
          case (op_q.mode)
            MODE_INSERT: begin
              if (hit_q) begin
                rsp_d.status = ST_DUP;
              end else if (table_full) begin
                rsp_d.status = ST_FULL;
              end else begin
                count_d = count_q + 1'b1;
              end
            end
            MODE_FIND: begin
              if (hit_q) begin
                rsp_d.ref_out   = DATA_W'(ref_hit_q);
                rsp_d.block_out = DATA_W'(blk_hit_q);
              end else begin
                rsp_d.status = ST_MISS;
              end
            end
            MODE_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
          rsp_d.entry_count = ENTRY_COUNT_W'(count_d);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers: request operands, search result and response.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q <= req_i.data;
    end
    if (tree_valid) begin
      {hit_q, ref_hit_q, blk_hit_q} <= tree_data;
    end
    rsp_q <= rsp_d;
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

`ifndef NO_ASSERTIONS
  // The fill count never runs past the table depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fill count exceeds depth");

  // A stored insert grows the table by exactly one entry.
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcast.insert |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the table by one");

  // A full report only comes from a table holding every entry.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (rsp_q.status == ST_FULL) |->
      rsp_q.entry_count == ENTRY_COUNT_W'(DEPTH))
    else $error("table full reported below depth");

  // The search result only returns while the controller waits for it.
  a_tree_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tree_valid |-> state_q == S_WAIT)
    else $error("search result arrived outside the wait step");
`endif

endmodule
